// ----- sv/c_subset_lexer_macros.svh -----
// Assertion helpers shared by the lexer modules.
// Each module that uses them has clk and rst_n in scope.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

`define LEX_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LEX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cslex_pkg.sv -----
`default_nettype none

package cslex_pkg;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_IDENT = 4'd1;
    localparam logic [3:0] M_INT   = 4'd2;
    localparam logic [3:0] M_BAR   = 4'd3;
    localparam logic [3:0] M_AMP   = 4'd4;
    localparam logic [3:0] M_EQ    = 4'd5;
    localparam logic [3:0] M_EXCL  = 4'd6;
    localparam logic [3:0] M_LT    = 4'd7;
    localparam logic [3:0] M_GT    = 4'd8;
    localparam logic [3:0] M_ERR   = 4'd9;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_INT    = 6'd2;
    localparam logic [5:0] K_IF     = 6'd3;
    localparam logic [5:0] K_ELSE   = 6'd4;
    localparam logic [5:0] K_WHILE  = 6'd5;
    localparam logic [5:0] K_RETURN = 6'd6;
    localparam logic [5:0] K_OROR   = 6'd7;
    localparam logic [5:0] K_OR     = 6'd8;
    localparam logic [5:0] K_XOR    = 6'd9;
    localparam logic [5:0] K_ANDAND = 6'd10;
    localparam logic [5:0] K_AND    = 6'd11;
    localparam logic [5:0] K_TILDE  = 6'd12;
    localparam logic [5:0] K_EQEQ   = 6'd13;
    localparam logic [5:0] K_ASSIGN = 6'd14;
    localparam logic [5:0] K_NE     = 6'd15;
    localparam logic [5:0] K_NOT    = 6'd16;
    localparam logic [5:0] K_SHL    = 6'd17;
    localparam logic [5:0] K_LE     = 6'd18;
    localparam logic [5:0] K_LTH    = 6'd19;
    localparam logic [5:0] K_SHR    = 6'd20;
    localparam logic [5:0] K_GE     = 6'd21;
    localparam logic [5:0] K_GTH    = 6'd22;
    localparam logic [5:0] K_PLUS   = 6'd23;
    localparam logic [5:0] K_MINUS  = 6'd24;
    localparam logic [5:0] K_STAR   = 6'd25;
    localparam logic [5:0] K_SLASH  = 6'd26;
    localparam logic [5:0] K_PCT    = 6'd27;
    localparam logic [5:0] K_LPAREN = 6'd28;
    localparam logic [5:0] K_RPAREN = 6'd29;
    localparam logic [5:0] K_COMMA  = 6'd30;
    localparam logic [5:0] K_SEMI   = 6'd31;
    localparam logic [5:0] K_ERR    = 6'd32;

    localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

    // Number of leading identifier characters kept in flops for keyword matching.
    localparam int KW_SHADOW = 6;

    localparam logic [1:0] OSEL_FIRST      = 2'd0;
    localparam logic [1:0] OSEL_SECOND_NOW = 2'd1;
    localparam logic [1:0] OSEL_CHAR       = 2'd2;
    localparam logic [1:0] OSEL_SECOND_REG = 2'd3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [7:0]  ch;
        logic [3:0]  pos;
        logic        last;
        logic        ovf;
    } tok_t;

    typedef struct packed {
        logic       accept;
        logic       rd_start;
        logic       load_out;
        logic [1:0] out_sel;
    } lex_cmd_t;

    typedef struct packed {
        logic f_single;
        logic f_run;
        logic s_now;
        logic char_last;
    } lex_stat_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = K_EOF;
        case (c)
            "^":     k = K_XOR;
            "~":     k = K_TILDE;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PCT;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] pend_mode(input logic [7:0] c);
        logic [3:0] m;
        m = M_IDLE;
        case (c)
            "|":     m = M_BAR;
            "&":     m = M_AMP;
            "=":     m = M_EQ;
            "!":     m = M_EXCL;
            "<":     m = M_LT;
            ">":     m = M_GT;
            default: m = M_IDLE;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] two_kind(input logic [3:0] m, input logic [7:0] c);
        logic [5:0] k;
        k = K_EOF;
        case (m)
            M_BAR:   if (c == "|") k = K_OROR;
            M_AMP:   if (c == "&") k = K_ANDAND;
            M_EQ:    if (c == "=") k = K_EQEQ;
            M_EXCL:  if (c == "=") k = K_NE;
            M_LT:
            begin
                if (c == "<") k = K_SHL;
                else if (c == "=") k = K_LE;
            end
            M_GT:
            begin
                if (c == ">") k = K_SHR;
                else if (c == "=") k = K_GE;
            end
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] held_kind(input logic [3:0] m);
        logic [5:0] k;
        k = K_EOF;
        case (m)
            M_BAR:   k = K_OR;
            M_AMP:   k = K_AND;
            M_EQ:    k = K_ASSIGN;
            M_EXCL:  k = K_NOT;
            M_LT:    k = K_LTH;
            M_GT:    k = K_GTH;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/cslex_ifs.sv -----
`default_nettype none

interface cslex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface cslex_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [30:0] int_value;
    logic [7:0]  ident_char;
    logic [3:0]  char_position;
    logic        last;
    logic        overflow;

    modport source (output valid, output token_kind, output int_value, output ident_char,
                    output char_position, output last, output overflow, input ready);
    modport sink (input valid, input token_kind, input int_value, input ident_char,
                  input char_position, input last, input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/c_subset_lexer.sv -----
// A single token is valid in the cycle after the byte that completes it is transferred; for an
// identifier run, each character is read into rd_data_reg and then into the output register.
// Throughput: one byte per cycle while each byte yields at most one token and output is free;
// a byte that yields two tokens, or flushes an identifier, holds off the next byte until each
// identifier character and any second token has been loaded for output.
// Reset (rst_n low, asynchronous) returns the lexer to idle with no pending token.
`default_nettype none

module c_subset_lexer
    import cslex_pkg::*;
#(
    parameter int MAX_IDENT_LEN = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    cslex_in_if.sink    chars,
    cslex_tok_if.source tokens
);

    lex_cmd_t  cmd;
    lex_stat_t stat;
    tok_t      tok;

    cslex_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .out_valid (tokens.valid),
        .out_ready (tokens.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cslex_dp #(
        .MAX_IDENT_LEN (MAX_IDENT_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (chars.char_code),
        .end_of_input (chars.end_of_input),
        .cmd          (cmd),
        .stat         (stat),
        .tok          (tok)
    );

    assign tokens.token_kind    = tok.kind;
    assign tokens.int_value     = tok.value;
    assign tokens.ident_char    = tok.ch;
    assign tokens.char_position = tok.pos;
    assign tokens.last          = tok.last;
    assign tokens.overflow      = tok.ovf;

endmodule

`default_nettype wire

// ----- sv/cslex_ctrl.sv -----
`default_nettype none
`include "c_subset_lexer_macros.svh"

module cslex_ctrl
    import cslex_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire lex_stat_t stat,
    output lex_cmd_t       cmd
);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_CHAR   = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       sec_pend_reg;
    logic       sec_pend_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_ACCEPT) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        sec_pend_next = sec_pend_reg;
        cmd           = '0;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    if (stat.f_run)
                    begin
                        cmd.rd_start  = 1'b1;
                        sec_pend_next = stat.s_now;
                        state_next    = ST_CHAR;
                    end
                    else if (stat.f_single)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OSEL_FIRST;
                        if (stat.s_now)
                        begin
                            state_next = ST_SECOND;
                        end
                    end
                    else if (stat.s_now)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OSEL_SECOND_NOW;
                    end
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OSEL_CHAR;
                    if (stat.char_last)
                    begin
                        state_next = sec_pend_reg ? ST_SECOND : ST_ACCEPT;
                    end
                end
            end
            ST_SECOND:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OSEL_SECOND_REG;
                    state_next   = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            sec_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_pend_reg  <= sec_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LEX_ASSERT(a_no_overwrite, cmd.load_out |-> out_free, "output register overwritten while a transfer is pending")
    `LEX_ASSERT(a_flush_exclusive, accept |-> !(stat.f_run && stat.f_single), "identifier run and single flush requested together")
    `LEX_ASSERT_NEXT(a_run_enters_char, accept && stat.f_run, state_reg == ST_CHAR, "identifier flush did not start character output")

endmodule

`default_nettype wire

// ----- sv/cslex_dp.sv -----
`default_nettype none
`include "c_subset_lexer_macros.svh"

module cslex_dp
    import cslex_pkg::*;
#(
    parameter int MAX_IDENT_LEN = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_input,
    input  wire lex_cmd_t   cmd,
    output lex_stat_t       stat,
    output tok_t            tok
);

    localparam int AW = $clog2(MAX_IDENT_LEN);
    localparam int LW = $clog2(MAX_IDENT_LEN + 1);

    logic [3:0]    mode_reg;
    logic [LW-1:0] len_reg;
    logic [30:0]   acc_reg;
    logic          ovf_reg;
    logic [7:0]    kw_reg [KW_SHADOW];
    logic [7:0]    mem [MAX_IDENT_LEN];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [5:0]    sec_kind_reg;
    tok_t          out_reg;

    logic          alpha;
    logic          digit;
    logic          space;
    logic [5:0]    skind;
    logic [3:0]    pmode;
    logic [5:0]    two;
    logic [5:0]    hkind;
    logic [5:0]    kw_kind;
    logic          cont;
    logic          err_hold;
    logic          flush;
    logic          start;
    logic          room;
    logic [5:0]    f_kind;
    logic [30:0]   f_value;
    logic          f_ovf;
    logic [5:0]    s_kind;
    logic [34:0]   acc_wide;
    logic          acc_sat;
    logic          mem_we;
    logic [LW-1:0] wr_pos;
    logic          rd_en;
    logic          load_char;
    logic [AW-1:0] rd_addr;
    tok_t          out_next;

    assign alpha    = is_alpha(char_code);
    assign digit    = is_digit(char_code);
    assign space    = is_space(char_code);
    assign skind    = single_kind(char_code);
    assign pmode    = pend_mode(char_code);
    assign two      = end_of_input ? K_EOF : two_kind(mode_reg, char_code);
    assign hkind    = held_kind(mode_reg);
    assign room     = len_reg < LW'(MAX_IDENT_LEN);
    assign cont     = !end_of_input &&
                      (((mode_reg == M_IDENT) && (alpha || digit)) ||
                       ((mode_reg == M_INT) && digit));
    assign err_hold = !end_of_input && (mode_reg == M_ERR);
    assign flush    = !cont && !err_hold && (two == K_EOF);
    assign start    = flush && !end_of_input;

    // A truncated name never matches a keyword.
    always_comb
    begin
        kw_kind = K_EOF;
        if (!ovf_reg)
        begin
            if (len_reg == LW'(2) && kw_reg[0] == "i" && kw_reg[1] == "f")
            begin
                kw_kind = K_IF;
            end
            else if (len_reg == LW'(4) && kw_reg[0] == "e" && kw_reg[1] == "l" &&
                     kw_reg[2] == "s" && kw_reg[3] == "e")
            begin
                kw_kind = K_ELSE;
            end
            else if (len_reg == LW'(5) && kw_reg[0] == "w" && kw_reg[1] == "h" &&
                     kw_reg[2] == "i" && kw_reg[3] == "l" && kw_reg[4] == "e")
            begin
                kw_kind = K_WHILE;
            end
            else if (len_reg == LW'(6) && kw_reg[0] == "r" && kw_reg[1] == "e" &&
                     kw_reg[2] == "t" && kw_reg[3] == "u" && kw_reg[4] == "r" &&
                     kw_reg[5] == "n")
            begin
                kw_kind = K_RETURN;
            end
        end
    end

    always_comb
    begin
        stat.f_run    = flush && (mode_reg == M_IDENT) && (kw_kind == K_EOF);
        stat.f_single = (two != K_EOF) ||
                        (flush && ((mode_reg == M_INT) || (hkind != K_EOF) ||
                                   ((mode_reg == M_IDENT) && (kw_kind != K_EOF))));
        stat.s_now    = end_of_input ||
                        (start && !space && !alpha && !digit && (pmode == M_IDLE));
        stat.char_last = (LW'(rd_idx_reg) + LW'(1)) == len_reg;
    end

    always_comb
    begin
        f_value = '0;
        f_ovf   = 1'b0;
        if (two != K_EOF)
        begin
            f_kind = two;
        end
        else if (mode_reg == M_INT)
        begin
            f_kind  = K_INT;
            f_value = acc_reg;
            f_ovf   = ovf_reg;
        end
        else if (mode_reg == M_IDENT)
        begin
            f_kind = kw_kind;
        end
        else
        begin
            f_kind = hkind;
        end
    end

    assign s_kind   = end_of_input ? K_EOF : ((skind != K_EOF) ? skind : K_ERR);
    assign acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                      35'(char_code[3:0]);
    assign acc_sat  = acc_wide > 35'(INT_MAX31);

    assign mem_we    = cmd.accept && !end_of_input &&
                       ((cont && (mode_reg == M_IDENT) && room) || (start && alpha));
    assign wr_pos    = start ? '0 : len_reg;
    assign load_char = cmd.load_out && (cmd.out_sel == OSEL_CHAR);
    assign rd_en     = cmd.rd_start || load_char;
    assign rd_addr   = cmd.rd_start ? '0 : AW'(rd_idx_reg + AW'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_pos[AW-1:0]] <= char_code;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KW_SHADOW; i++)
        begin
            if (mem_we && wr_pos == LW'(i))
            begin
                kw_reg[i] <= char_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (end_of_input)
            begin
                mode_reg <= M_IDLE;
            end
            else if (cont)
            begin
                if (mode_reg == M_IDENT)
                begin
                    if (room)
                    begin
                        len_reg <= len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                else
                begin
                    acc_reg <= acc_sat ? INT_MAX31 : acc_wide[30:0];
                    if (acc_sat)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            else if (two != K_EOF)
            begin
                mode_reg <= M_IDLE;
            end
            else if (start)
            begin
                if (space)
                begin
                    mode_reg <= M_IDLE;
                end
                else if (alpha)
                begin
                    mode_reg <= M_IDENT;
                    len_reg  <= LW'(1);
                    ovf_reg  <= 1'b0;
                end
                else if (digit)
                begin
                    mode_reg <= M_INT;
                    acc_reg  <= 31'(char_code[3:0]);
                    ovf_reg  <= 1'b0;
                end
                else if (pmode != M_IDLE)
                begin
                    mode_reg <= pmode;
                end
                else if (skind != K_EOF)
                begin
                    mode_reg <= M_IDLE;
                end
                else
                begin
                    mode_reg <= M_ERR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (load_char)
        begin
            rd_idx_reg <= AW'(rd_idx_reg + AW'(1));
        end
    end

    always_comb
    begin
        out_next      = '0;
        out_next.last = 1'b1;
        case (cmd.out_sel)
            OSEL_FIRST:
            begin
                out_next.kind  = f_kind;
                out_next.value = f_value;
                out_next.ovf   = f_ovf;
            end
            OSEL_SECOND_NOW:
            begin
                out_next.kind = s_kind;
            end
            OSEL_CHAR:
            begin
                out_next.kind = K_IDENT;
                out_next.ch   = rd_data_reg;
                out_next.pos  = 4'(rd_idx_reg);
                out_next.last = stat.char_last;
                out_next.ovf  = ovf_reg;
            end
            OSEL_SECOND_REG:
            begin
                out_next.kind = sec_kind_reg;
            end
            default:
            begin
                out_next.kind = K_ERR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sec_kind_reg <= s_kind;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign tok = out_reg;

    `LEX_ASSERT(a_len_bound, len_reg <= LW'(MAX_IDENT_LEN), "identifier length beyond buffer")
    `LEX_ASSERT(a_mode_legal, mode_reg <= M_ERR, "lexer mode outside the defined codes")
    `LEX_ASSERT(a_char_in_run, load_char |-> (LW'(rd_idx_reg) < len_reg), "read past identifier end")

endmodule

`default_nettype wire
